@@ rtl/sample_without_replacement_core_macros.svh @@
// Assertion macros shared by the sampling core RTL.
`ifndef SAMPLE_WITHOUT_REPLACEMENT_CORE_MACROS_SVH
`define SAMPLE_WITHOUT_REPLACEMENT_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/swr_pkg.sv @@
// Package for the sampling core: widths, codes, state and control types.
package swr_pkg;

  localparam int WORD_W        = 32;
  localparam int CNT_W         = 9;
  localparam int OUT_W         = 8;
  localparam int CFG_IDX_W     = 1;
  localparam int MAX_RANGE_DEF = 256;
  localparam int CFG_RESET     = 256;
  localparam int GROUP         = 16;
  localparam int CAP_LIMIT     = (1 << CNT_W) - 1;
  localparam int STEP_W        = $clog2(WORD_W);

  localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SEL,
    ST_MERGE,
    ST_RESULT
  } swr_state_t;

  typedef struct packed {
    logic             refill;
    logic             shift;
    logic [CNT_W-1:0] pos;
  } swr_cell_ctrl_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } swr_div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } swr_div_rsp_t;

endpackage

@@ rtl/sample_without_replacement_core.sv @@
// Top level of the sampling core: control, draw counter, cell chain and selection tree.
//
// Draws distinct values from 0..N-1, N being set_size capped at SIZE_CAP, one
// result per request. A request is taken only while the core is idle; a restart
// in the request refills the list and clears the draw count in the acceptance
// cycle. A draw goes from acceptance through a check state, the bit-serial
// remainder unit (32 steps of word mod remaining count, then its done flag), the
// selection tree (group registers, then the merge into the result register) while
// the cell chain shifts down, and the load of the output register. An exhausted
// draw goes from the check state straight to the result state. The core returns
// to idle as the result is loaded and takes its next request from there. Reset
// loads the list directly; there is no clearing pass. The output register lets a
// finished result wait on out_stall while the core takes its next request; that
// next result then waits in the core until the register frees.
module sample_without_replacement_core
  import swr_pkg::*;
#(
  parameter int MAX_RANGE = MAX_RANGE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_W-1:0]    in_random_word,
  input  logic                 in_restart,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_W-1:0]     out_picked_value,
  output logic                 out_last_pick,
  output logic                 out_exhausted,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_wdata
);

  `include "sample_without_replacement_core_macros.svh"

  localparam int VW       = $clog2(MAX_RANGE);
  localparam int SIZE_CAP = (MAX_RANGE < CAP_LIMIT) ? MAX_RANGE : CAP_LIMIT;
  localparam int NG       = (SIZE_CAP + GROUP - 1) / GROUP;

  swr_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  set_size_r, pick_count_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [WORD_W-1:0] word_r;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [OUT_W-1:0]  res_val_r, res_val_nxt;
  logic              res_last_r, res_last_nxt;
  logic              res_exh_r, res_exh_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_val_r;
  logic              out_last_r, out_exh_r;
  logic              out_load;
  logic              in_acc;
  logic [CNT_W-1:0]  eff_w, left_w;
  logic              possible;
  logic [VW-1:0]     merged;

  swr_cell_ctrl_t    cell_ctrl;
  swr_div_req_t      div_req;
  swr_div_rsp_t      div_rsp;

  logic [VW-1:0]     cell_val [MAX_RANGE];
  logic [VW-1:0]     grp_r    [NG];
  logic [VW-1:0]     grp_nxt  [NG];

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign eff_w    = ({1'b0, set_size_r} > (CNT_W + 1)'(SIZE_CAP)) ?
                    CNT_W'(SIZE_CAP) : set_size_r;
  assign possible = (count_r < eff_w) && (count_r < pick_count_r);
  assign left_w   = eff_w - count_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r   <= CNT_W'(CFG_RESET);
      pick_count_r <= CNT_W'(CFG_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_SIZE:   set_size_r   <= cfg_wdata;
        REG_PICK_COUNT: pick_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // cell chain
  assign cell_ctrl.refill = in_acc && in_restart;
  assign cell_ctrl.shift  = (state_r == ST_SEL);
  assign cell_ctrl.pos    = pos_r;

  for (genvar j = 0; j < MAX_RANGE; j++) begin : g_cell
    logic [VW-1:0] nb;
    if (j == MAX_RANGE - 1) begin : g_top
      assign nb = cell_val[j];
    end else begin : g_mid
      assign nb = cell_val[j+1];
    end
    swr_cell #(
      .VW  (VW),
      .IDX (j)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .next_val (nb),
      .val      (cell_val[j])
    );
  end

  // selection tree: groups of cells, then groups
  for (genvar g = 0; g < NG; g++) begin : g_grp
    localparam int LO = g * GROUP;
    localparam int HI = (LO + GROUP < SIZE_CAP) ? LO + GROUP : SIZE_CAP;
    always_comb begin
      grp_nxt[g] = '0;
      for (int k = LO; k < HI; k++) begin
        if (pos_r == CNT_W'(k)) begin
          grp_nxt[g] = grp_nxt[g] | cell_val[k];
        end
      end
    end
    always_ff @(posedge clk) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  always_comb begin
    merged = '0;
    for (int g = 0; g < NG; g++) begin
      merged = merged | grp_r[g];
    end
  end

  // remainder unit
  assign div_req.start    = (state_r == ST_CHECK) && possible;
  assign div_req.dividend = word_r;
  assign div_req.divisor  = left_w;

  swr_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // control
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    res_val_nxt   = res_val_r;
    res_last_nxt  = res_last_r;
    res_exh_nxt   = res_exh_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_restart) begin
            count_nxt = '0;
          end
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (possible) begin
          res_exh_nxt = 1'b0;
          state_nxt   = ST_DIV;
        end else begin
          res_val_nxt  = '0;
          res_last_nxt = 1'b0;
          res_exh_nxt  = 1'b1;
          state_nxt    = ST_RESULT;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          pos_nxt   = div_rsp.rem;
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        count_nxt = count_r + 1'b1;
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        res_val_nxt  = OUT_W'(merged);
        res_last_nxt = (count_r == pick_count_r);
        state_nxt    = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      word_r <= in_random_word;
    end
    pos_r      <= pos_nxt;
    res_val_r  <= res_val_nxt;
    res_last_r <= res_last_nxt;
    res_exh_r  <= res_exh_nxt;
    if (out_load) begin
      out_val_r  <= res_val_r;
      out_last_r <= res_last_r;
      out_exh_r  <= res_exh_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_picked_value = out_val_r;
  assign out_last_pick    = out_last_r;
  assign out_exhausted    = out_exh_r;

  `SWR_ASSERT_IMP(a_exh_clean, clk, rst_n, out_valid && out_exhausted,
                  out_picked_value == '0 && !out_last_pick, "exhausted result carries data")
  `SWR_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_r <= CNT_W'(SIZE_CAP),
                  "draw count above range")
  `SWR_ASSERT_NXT(a_sel_count, clk, rst_n, state_r == ST_SEL,
                  count_r == CNT_W'($past(count_r) + 1'b1), "count did not advance on shift")
  `SWR_ASSERT_IMP(a_pos_range, clk, rst_n, state_r == ST_SEL, pos_r < left_w,
                  "position beyond remaining list")

endmodule

@@ rtl/swr_cell.sv @@
// One list cell: holds a value, refills to its index, shifts down from its upper neighbor.
module swr_cell
  import swr_pkg::*;
#(
  parameter int VW  = 8,
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  swr_cell_ctrl_t ctrl,
  input  logic [VW-1:0]  next_val,
  output logic [VW-1:0]  val
);

  localparam bit FAR = (IDX >= (1 << CNT_W));

  logic [VW-1:0] val_r;
  logic          at_or_above;

  assign at_or_above = FAR || (ctrl.pos <= CNT_W'(IDX));
  assign val         = val_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.refill) begin
      val_r <= VW'(IDX);
    end else if (ctrl.shift && at_or_above) begin
      val_r <= next_val;
    end
  end

endmodule

@@ rtl/swr_divider.sv @@
// Bit-serial restoring remainder unit: 32-bit word mod a 9-bit divisor.
module swr_divider
  import swr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  swr_div_req_t req,
  output swr_div_rsp_t rsp
);

  `include "sample_without_replacement_core_macros.svh"

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;

  assign trial = {rem_r, word_r[WORD_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    word_nxt = word_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      word_nxt = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      word_nxt = {word_r[WORD_W-2:0], 1'b0};
      rem_nxt  = (trial >= {1'b0, div_r}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

  `SWR_ASSERT_NXT(a_div_start_busy, clk, rst_n, req.start, busy_r, "divider not busy after start")
  `SWR_ASSERT_NXT(a_div_last_done, clk, rst_n, busy_r && !req.start && cnt_r == LAST_STEP, done_r, "divider missed done")
  `SWR_ASSERT_IMP(a_div_rem_range, clk, rst_n, done_r, rem_r < div_r, "remainder not below divisor")

endmodule

@@ tb/sample_without_replacement_core_tb.sv @@
// Self-checking testbench for the sampling core: directed table, then random sets.
`timescale 1ns / 1ps

module sample_without_replacement_core_tb;
  import swr_pkg::*;

  localparam int POOL_N = MAX_RANGE_DEF;
  localparam int N_DIR  = 21;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             last;
    logic             exh;
  } draw_t;

  typedef struct packed {
    logic              cfg;
    logic [CNT_W-1:0]  size;
    logic [CNT_W-1:0]  pick;
    logic [WORD_W-1:0] word;
    logic              restart;
    logic              known;
    logic [OUT_W-1:0]  value;
    logic              last;
    logic              exh;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [WORD_W-1:0]    in_random_word;
  logic                 in_restart;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUT_W-1:0]     out_picked_value;
  logic                 out_last_pick;
  logic                 out_exhausted;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_wdata;

  // predictor state
  logic [OUT_W-1:0] pool [POOL_N];
  logic [CNT_W-1:0] draws_made;
  logic [CNT_W-1:0] size_reg;
  logic [CNT_W-1:0] pick_reg;

  draw_t     pending_draws[$];
  stim_row_t dir_tab [N_DIR];
  int        errors;
  int        n_req;
  int        n_res;
  int        n_exh;
  int        n_last;
  int        n_cfg;
  int        send_idle_pct;
  int        stall_pct;

  sample_without_replacement_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_random_word   (in_random_word),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_picked_value (out_picked_value),
    .out_last_pick    (out_last_pick),
    .out_exhausted    (out_exhausted),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Timeout at %0t", $time);
    $display("Some tests failed");
    $finish;
  end

  function automatic void refill_pool();
    for (int i = 0; i < POOL_N; i++) pool[i] = i[OUT_W-1:0];
    draws_made = '0;
  endfunction

  function automatic draw_t predict_draw(logic [WORD_W-1:0] word, logic restart);
    int unsigned eff;
    int unsigned left;
    int unsigned pos;
    draw_t       d;
    if (restart) refill_pool();
    eff = (size_reg > POOL_N) ? POOL_N : size_reg;
    if (draws_made >= eff || draws_made >= pick_reg) begin
      d = '{value: '0, last: 1'b0, exh: 1'b1};
      return d;
    end
    left = eff - draws_made;
    pos  = word % left;
    d.value = pool[pos];
    for (int j = pos; j + 1 < POOL_N; j++) pool[j] = pool[j + 1];
    draws_made = draws_made + 1'b1;
    d.last = (draws_made == pick_reg);
    d.exh  = 1'b0;
    return d;
  endfunction

  // result side: random stall, compare against oldest expectation
  always @(posedge clk) begin
    draw_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_res++;
      if (out_exhausted) n_exh++;
      if (out_last_pick) n_last++;
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected result value=%0d last=%0b exh=%0b", $time,
                 out_picked_value, out_last_pick, out_exhausted);
        errors++;
      end else begin
        e = pending_draws.pop_front();
        if (out_picked_value !== e.value) begin
          $display("%0t: picked_value exp %0d got %0d", $time, e.value, out_picked_value);
          errors++;
        end
        if (out_last_pick !== e.last) begin
          $display("%0t: last_pick exp %0b got %0b", $time, e.last, out_last_pick);
          errors++;
        end
        if (out_exhausted !== e.exh) begin
          $display("%0t: exhausted exp %0b got %0b", $time, e.exh, out_exhausted);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_req(logic [WORD_W-1:0] word, logic restart, logic fixed,
                          draw_t fixed_res);
    draw_t d;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_random_word <= word;
    in_restart     <= restart;
    do @(posedge clk); while (in_stall);
    d = predict_draw(word, restart);
    pending_draws.push_back(fixed ? fixed_res : d);
    n_req++;
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_cfg(logic [CNT_W-1:0] size, logic [CNT_W-1:0] pick);
    drain_requests();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SET_SIZE;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_index <= REG_PICK_COUNT;
    cfg_wdata <= pick;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    size_reg = size;
    pick_reg = pick;
    n_cfg++;
  endtask

  function automatic logic [CNT_W-1:0] rand_size();
    case ($urandom_range(0, 11))
      0:       return 9'd1;
      1:       return 9'd256;
      2:       return 9'd2;
      3:       return CNT_W'($urandom_range(257, 511));
      4:       return 9'd0;
      5:       return CNT_W'($urandom_range(25, 255));
      default: return CNT_W'($urandom_range(3, 24));
    endcase
  endfunction

  initial begin
    int unsigned eff;
    int unsigned set_len;
    int unsigned run;
    int          ph_items;
    logic [CNT_W-1:0] sz;
    logic [CNT_W-1:0] pk;
    stim_row_t r;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_random_word = '0;
    in_restart     = 1'b0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_SET_SIZE;
    cfg_wdata      = '0;
    errors = 0; n_req = 0; n_res = 0; n_exh = 0; n_last = 0; n_cfg = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    refill_pool();
    size_reg = CNT_W'(CFG_RESET);
    pick_reg = CNT_W'(CFG_RESET);

    //           cfg size  pick  word           rst known val   last exh
    dir_tab = '{
      '{1'b0, 9'd0,   9'd0,   32'h0000_0000, 1'b0, 1'b1, 8'd0,   1'b0, 1'b0},
      '{1'b0, 9'd0,   9'd0,   32'hFFFF_FFFF, 1'b1, 1'b1, 8'd255, 1'b0, 1'b0},
      '{1'b1, 9'd1,   9'd1,   32'hFFFF_FFFF, 1'b1, 1'b1, 8'd0,   1'b1, 1'b0},
      '{1'b0, 9'd0,   9'd0,   32'h0000_0005, 1'b0, 1'b1, 8'd0,   1'b0, 1'b1},
      '{1'b0, 9'd0,   9'd0,   32'h0000_0000, 1'b1, 1'b1, 8'd0,   1'b1, 1'b0},
      '{1'b1, 9'd0,   9'd256, 32'h0000_0007, 1'b1, 1'b1, 8'd0,   1'b0, 1'b1},
      '{1'b1, 9'd256, 9'd0,   32'h0000_1234, 1'b1, 1'b1, 8'd0,   1'b0, 1'b1},
      '{1'b1, 9'd511, 9'd511, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'd255, 1'b0, 1'b0},
      '{1'b0, 9'd0,   9'd0,   32'h8000_0000, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
      '{1'b1, 9'd3,   9'd5,   32'h0000_0002, 1'b1, 1'b1, 8'd2,   1'b0, 1'b0},
      '{1'b0, 9'd0,   9'd0,   32'h0000_0001, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
      '{1'b0, 9'd0,   9'd0,   32'h0000_0000, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
      '{1'b0, 9'd0,   9'd0,   32'h0000_0000, 1'b0, 1'b1, 8'd0,   1'b0, 1'b1},
      // config change mid-set, no restart
      '{1'b1, 9'd8,   9'd8,   32'h1234_5678, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
      '{1'b1, 9'd2,   9'd256, 32'h0F0F_0F0F, 1'b0, 1'b1, 8'd0,   1'b0, 1'b1},
      '{1'b1, 9'd256, 9'd256, 32'hAAAA_AAAA, 1'b1, 1'b1, 8'd170, 1'b0, 1'b0},
      '{1'b0, 9'd0,   9'd0,   32'h5555_5555, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
      '{1'b1, 9'd16,  9'd16,  32'hDEAD_BEEF, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0},
      '{1'b1, 9'd2,   9'd2,   32'h0000_0001, 1'b1, 1'b1, 8'd1,   1'b0, 1'b0},
      '{1'b0, 9'd0,   9'd0,   32'h0000_0000, 1'b0, 1'b1, 8'd0,   1'b1, 1'b0},
      '{1'b0, 9'd0,   9'd0,   32'h0000_0000, 1'b0, 1'b1, 8'd0,   1'b0, 1'b1}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      r = dir_tab[i];
      if (r.cfg) set_cfg(r.size, r.pick);
      send_req(r.word, r.restart, r.known, '{value: r.value, last: r.last, exh: r.exh});
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      if (ph == 0) begin
        sz = 9'd256; pk = 9'd256;
      end else if (ph == 1) begin
        sz = 9'd1; pk = 9'd1;
      end else begin
        sz = rand_size();
        eff = (sz > POOL_N) ? POOL_N : sz;
        case ($urandom_range(0, 9))
          0:       pk = 9'd1;
          1:       pk = 9'd256;
          2:       pk = 9'd0;
          default: pk = CNT_W'($urandom_range(1, (eff > 0 ? eff : 1) + 2));
        endcase
      end
      set_cfg(sz, pk);
      eff = (sz > POOL_N) ? POOL_N : sz;
      set_len = (eff < pk) ? eff : pk;
      if (set_len == 0) set_len = 1;
      ph_items = 0;
      for (int s = 0; ph_items < 112; s++) begin
        run = set_len;
        if ($urandom_range(0, 99) < 15) run = $urandom_range(1, set_len);
        run += $urandom_range(0, 2);
        for (int k = 0; k < run && ph_items < 112; k++) begin
          send_req($urandom, (k == 0) || ($urandom_range(0, 19) == 0), 1'b0, '0);
          ph_items++;
        end
        // hold off until the core has delivered everything
        if (s == 1) drain_requests();
      end
    end

    drain_requests();
    repeat (40) @(posedge clk);
    if (pending_draws.size() != 0) errors++;
    $display("Covered %0d requests, %0d results (%0d exhausted, %0d set ends), %0d configs",
             n_req, n_res, n_exh, n_last, n_cfg);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
